/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL; they sample on clk and stay off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a condition at every rising clock edge.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant check failed");

// Check a consequence in the same cycle as its trigger.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Check a consequence in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/jtms_pkg.sv */
// Shared types, constants and helpers of the joystick twist mixer smoother.
package jtms_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = SLOT_W + 1;
  localparam int SMP_W      = 32;
  localparam int SUM_W      = SMP_W + SLOT_W;
  localparam int DIV_BITS   = 6;
  localparam int DIV_CYCLES = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);
  localparam int GAIN_W     = 16;
  localparam int AXIS_W     = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(10);
  localparam logic [GAIN_W-1:0] RESET_LIN_GAIN = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] RESET_ANG_GAIN = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] RESET_BOOST_GAIN = '0;

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINEAR_GAIN  = 3'd0,
    REG_ANGULAR_GAIN = 3'd1,
    REG_BOOST_GAIN   = 3'd2,
    REG_LINEAR_LEN   = 3'd3,
    REG_ANGULAR_LEN  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_PROD,
    SC_LO,
    SC_HI,
    SC_FIN
  } sc_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_ABS,
    L_DIV,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] lin;
    logic [GAIN_W-1:0] ang;
    logic [GAIN_W-1:0] boost;
  } gains_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SMP_W-1:0] lin;
    logic signed [SMP_W-1:0] ang;
  } smp_t;

  typedef struct packed {
    logic                    done;
    logic signed [SMP_W-1:0] avg;
  } lane_st_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MAX_WINDOW)) begin
      r = LEN_W'(MAX_WINDOW);
    end
    return r;
  endfunction

endpackage

/* rtl/joystick_twist_mixer_smoother_unit.sv */
// Top level of the joystick twist mixer smoother: config registers, lanes and output merge.
//
// Each input beat carries a linear and an angular joystick axis in Q1.15. The linear axis is
// scaled by linear_gain; the angular axis by angular_gain and a turn boost that grows as the
// forward axis shrinks. Both samples then enter two side-by-side moving-average lanes, each
// a 16-entry ring with a running sum divided by its window length, and the output stage joins
// the two averages into one result beat of saturated Q16.15 values. On its way from acceptance
// to out_tvalid a beat passes through the scaling unit, whose 32 x 33 bit boost product is
// built from two 16-bit partial products, the window sum update and magnitude step, the
// divider at 6 quotient bits per cycle, and the output register load. in_tready drops on
// acceptance and rises once the result sits in the output register, so a new beat is taken
// only after the last result is loaded, and a waiting result does not hold off the next beat.
// A window length write clears that lane's window.
`include "assert_macros.svh"

module joystick_twist_mixer_smoother_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [31:0]                          in_tdata,    // [15:0] forward axis, [31:16] turn axis
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [63:0]                          out_tdata,   // [31:0] linear_velocity, [63:32] angular_velocity
  input  logic                                 cfg_wr_en,
  input  logic [jtms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jtms_pkg::GAIN_W-1:0]          cfg_wr_data
);
  import jtms_pkg::*;

  gains_t   gains_r;
  logic     busy_r;
  logic     out_valid_r;
  logic [63:0] out_data_r;

  logic     in_fire;
  logic     load;
  logic     lin_clr, ang_clr;
  logic [LEN_W-1:0] len_wr;
  smp_t     smp;
  lane_st_t lin_st, ang_st;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = !busy_r;
  assign load = lin_st.done && ang_st.done && (!out_valid_r || out_tready);
  assign len_wr = clamp_len(cfg_wr_data[LEN_W-1:0]);
  assign lin_clr = cfg_wr_en && (cfg_index == REG_LINEAR_LEN);
  assign ang_clr = cfg_wr_en && (cfg_index == REG_ANGULAR_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.lin   <= RESET_LIN_GAIN;
      gains_r.ang   <= RESET_ANG_GAIN;
      gains_r.boost <= RESET_BOOST_GAIN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LINEAR_GAIN:  gains_r.lin   <= cfg_wr_data;
        REG_ANGULAR_GAIN: gains_r.ang   <= cfg_wr_data;
        REG_BOOST_GAIN:   gains_r.boost <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  jtms_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .lin_axis ($signed(in_tdata[15:0])),
    .ang_axis ($signed(in_tdata[31:16])),
    .gains    (gains_r),
    .smp      (smp)
  );

  jtms_avg_lane u_lin_lane (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (smp.valid),
    .sample (smp.lin),
    .clr    (lin_clr),
    .len_wr (len_wr),
    .take   (load),
    .st     (lin_st)
  );

  jtms_avg_lane u_ang_lane (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (smp.valid),
    .sample (smp.ang),
    .clr    (ang_clr),
    .len_wr (len_wr),
    .take   (load),
    .st     (ang_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {ang_st.avg, lin_st.avg};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_ALWAYS(a_lanes_lockstep, lin_st.done == ang_st.done)
  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `ASSERT_SAME(a_result_from_item, $rose(out_tvalid), $past(busy_r))

endmodule

/* rtl/jtms_scale.sv */
// Gain and turn-boost scaling of one joystick beat into two Q16.15 samples.
module jtms_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [jtms_pkg::AXIS_W-1:0]   lin_axis,
  input  logic signed [jtms_pkg::AXIS_W-1:0]   ang_axis,
  input  jtms_pkg::gains_t                     gains,
  output jtms_pkg::smp_t                       smp
);
  import jtms_pkg::*;

  localparam logic [31:0] ONE_Q23 = 32'h0080_0000;
  localparam logic [16:0] ONE_Q15 = 17'h0_8000;

  sc_state_t state_r, state_nxt;

  logic signed [AXIS_W-1:0] lin_r, ang_r;
  logic signed [32:0]       lin_prod_r, ang_sc_r;
  logic [31:0]              boost_r;
  logic [15:0]              fac_hi_r;
  logic signed [49:0]       p_lo_r, p_hi_r;
  logic                     valid_r;
  logic signed [SMP_W-1:0]  lin_smp_r, ang_smp_r;

  logic [16:0]              mag;
  logic [16:0]              comp;
  logic signed [16:0]       lin_g_s, ang_g_s;
  logic signed [32:0]       lin_prod_nxt, ang_sc_nxt;
  logic [32:0]              boost_nxt;
  logic [31:0]              factor;
  logic signed [16:0]       fac_lo_s, fac_hi_s;
  logic signed [49:0]       p_lo_nxt, p_hi_nxt;
  logic signed [65:0]       full;
  logic signed [34:0]       sh;
  logic signed [SMP_W-1:0]  ang_smp_nxt;

  always_comb begin
    mag          = lin_r[AXIS_W-1] ? 17'(-$signed({lin_r[AXIS_W-1], lin_r}))
                                   : 17'({1'b0, lin_r});
    comp         = ONE_Q15 - mag;
    lin_g_s      = $signed({1'b0, gains.lin});
    ang_g_s      = $signed({1'b0, gains.ang});
    lin_prod_nxt = lin_r * lin_g_s;
    ang_sc_nxt   = ang_r * ang_g_s;
    boost_nxt    = comp * gains.boost;
    factor       = ONE_Q23 + boost_r;
    fac_lo_s     = $signed({1'b0, factor[15:0]});
    fac_hi_s     = $signed({1'b0, fac_hi_r});
    p_lo_nxt     = fac_lo_s * ang_sc_r;
    p_hi_nxt     = fac_hi_s * ang_sc_r;
    full         = (66'(p_hi_r) <<< 16) + 66'(p_lo_r);
    sh           = full[65:31];
    if (sh[34:31] != {4{sh[31]}}) begin
      ang_smp_nxt = sh[34] ? SMP_MIN : SMP_MAX;
    end else begin
      ang_smp_nxt = sh[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE: if (start) state_nxt = SC_PROD;
      SC_PROD: state_nxt = SC_LO;
      SC_LO:   state_nxt = SC_HI;
      SC_HI:   state_nxt = SC_FIN;
      SC_FIN:  state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == SC_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SC_IDLE && start) begin
      lin_r <= lin_axis;
      ang_r <= ang_axis;
    end
    if (state_r == SC_PROD) begin
      lin_prod_r <= lin_prod_nxt;
      ang_sc_r   <= ang_sc_nxt;
      boost_r    <= boost_nxt[31:0];
    end
    if (state_r == SC_LO) begin
      p_lo_r   <= p_lo_nxt;
      fac_hi_r <= factor[31:16];
    end
    if (state_r == SC_HI) begin
      p_hi_r <= p_hi_nxt;
    end
    if (state_r == SC_FIN) begin
      lin_smp_r <= SMP_W'($signed(lin_prod_r[32:8]));
      ang_smp_r <= ang_smp_nxt;
    end
  end

  assign smp.valid = valid_r;
  assign smp.lin   = lin_smp_r;
  assign smp.ang   = ang_smp_r;

endmodule

/* rtl/jtms_avg_lane.sv */
// One moving-average lane: sample ring, running sum and iterative divide by the length.
module jtms_avg_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [jtms_pkg::SMP_W-1:0]   sample,
  input  logic                                clr,
  input  logic [jtms_pkg::LEN_W-1:0]          len_wr,
  input  logic                                take,
  output jtms_pkg::lane_st_t                  st
);
  import jtms_pkg::*;

  lane_state_t state_r, state_nxt;

  logic signed [SMP_W-1:0] ring_r [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]   valid_r;
  logic [SLOT_W-1:0]       slot_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [LEN_W-1:0]        len_r;
  logic [CNT_W-1:0]        div_cnt_r;
  logic [SUM_W-1:0]        dvd_r;
  logic [LEN_W-1:0]        rem_r;
  logic                    neg_r;

  logic [SLOT_W-1:0]       s_cur;
  logic [LEN_W-1:0]        s_inc;
  logic [SLOT_W-1:0]       slot_nxt;
  logic signed [SMP_W-1:0] old;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0]        dvd_nxt;
  logic [LEN_W-1:0]        rem_nxt;
  logic                    pos_ovf, neg_ovf;

  always_comb begin
    s_cur    = ({1'b0, slot_r} >= len_r) ? '0 : slot_r;
    s_inc    = {1'b0, s_cur} + LEN_W'(1);
    slot_nxt = (s_inc >= len_r) ? '0 : s_inc[SLOT_W-1:0];
    old      = valid_r[s_cur] ? ring_r[s_cur] : '0;
    sum_nxt  = sum_r - SUM_W'(old) + SUM_W'(sample);
  end

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [LEN_W-1:0] r;
    logic [SUM_W-1:0] q;
    r = rem_r;
    q = dvd_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[LEN_W-2:0], q[SUM_W-1]};
      q = {q[SUM_W-2:0], 1'b0};
      if (r >= len_r) begin
        r    = r - len_r;
        q[0] = 1'b1;
      end
    end
    rem_nxt = r;
    dvd_nxt = q;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE:  if (start) state_nxt = L_ABS;
      L_ABS:   state_nxt = L_DIV;
      L_DIV:   if (div_cnt_r == CNT_W'(DIV_CYCLES - 1)) state_nxt = L_DONE;
      L_DONE:  if (take) state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= L_IDLE;
      valid_r   <= '0;
      slot_r    <= '0;
      sum_r     <= '0;
      len_r     <= RESET_LEN;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        valid_r <= '0;
        slot_r  <= '0;
        sum_r   <= '0;
        len_r   <= len_wr;
      end else if (state_r == L_IDLE && start) begin
        valid_r[s_cur] <= 1'b1;
        slot_r         <= slot_nxt;
        sum_r          <= sum_nxt;
      end
      if (state_r == L_ABS) begin
        div_cnt_r <= '0;
      end else if (state_r == L_DIV) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!clr && state_r == L_IDLE && start) begin
      ring_r[s_cur] <= sample;
    end
    if (state_r == L_ABS) begin
      neg_r <= sum_r[SUM_W-1];
      dvd_r <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      rem_r <= '0;
    end else if (state_r == L_DIV) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    pos_ovf = |dvd_r[SUM_W-1:SMP_W-1];
    neg_ovf = dvd_r > SUM_W'({1'b1, {(SMP_W-1){1'b0}}});
    st.done = (state_r == L_DONE);
    if (neg_r) begin
      st.avg = neg_ovf ? SMP_MIN : -$signed(dvd_r[SMP_W-1:0]);
    end else begin
      st.avg = pos_ovf ? SMP_MAX : $signed(dvd_r[SMP_W-1:0]);
    end
  end

endmodule

/* tb/sv/twist_mix_monitor.sv */
// Monitor for the joystick twist mixer smoother: predicts every velocity beat and compares it.
module twist_mix_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [31:0]                    in_tdata,    // [15:0] forward axis, [31:16] turn axis
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [63:0]                    out_tdata,   // [31:0] linear_velocity, [63:32] angular_velocity
  input  logic                           cfg_wr_en,
  input  logic [jtms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jtms_pkg::GAIN_W-1:0]    cfg_wr_data,
  output int                             pending_velocities,
  output int                             mismatches
);
  import jtms_pkg::*;

  localparam int     LIN_CH     = 0;
  localparam int     ANG_CH     = 1;
  localparam longint UNITY_Q15  = 64'sd32768;
  localparam longint UNITY_Q23  = 64'sd8388608;

  longint      lin_gain;
  longint      ang_gain;
  longint      boost_gain;
  longint      ring [2][MAX_WINDOW];
  longint      run_sum [2];
  longint      win_len [2];
  int          slot [2];
  logic [63:0] expected_velocities [$];
  logic [63:0] want;
  logic [63:0] fresh;

  function automatic longint window_of(input logic [GAIN_W-1:0] v);
    longint n;
    n = longint'(v[4:0]);
    if (n < 1) begin
      n = 1;
    end
    if (n > MAX_WINDOW) begin
      n = MAX_WINDOW;
    end
    return n;
  endfunction

  function automatic longint clip32(input longint x);
    if (x > longint'(SMP_MAX)) begin
      return longint'(SMP_MAX);
    end
    if (x < longint'(SMP_MIN)) begin
      return longint'(SMP_MIN);
    end
    return x;
  endfunction

  task automatic clear_window(input int ch, input longint len);
    for (int i = 0; i < MAX_WINDOW; i++) begin
      ring[ch][i] = 0;
    end
    run_sum[ch] = 0;
    slot[ch]    = 0;
    win_len[ch] = len;
  endtask

  task automatic smooth(input int ch, input longint smp, output longint avg);
    int s;
    s = slot[ch];
    if (s >= win_len[ch]) begin
      s = 0;
    end
    run_sum[ch] = run_sum[ch] - ring[ch][s] + smp;
    ring[ch][s] = smp;
    s++;
    slot[ch] = (s >= win_len[ch]) ? 0 : s;
    avg = clip32(run_sum[ch] / win_len[ch]);
  endtask

  task automatic mix_and_smooth(input logic [31:0] d, output logic [63:0] vel);
    longint lin;
    longint ang;
    longint mag;
    longint lin_q;
    longint factor;
    longint ang_q;
    longint lin_avg;
    longint ang_avg;
    lin    = longint'($signed(d[15:0]));
    ang    = longint'($signed(d[31:16]));
    mag    = (lin < 0) ? -lin : lin;
    lin_q  = (lin * lin_gain) >>> 8;
    factor = UNITY_Q23 + (UNITY_Q15 - mag) * boost_gain;
    ang_q  = (factor * (ang * ang_gain)) >>> 31;
    smooth(LIN_CH, clip32(lin_q), lin_avg);
    smooth(ANG_CH, clip32(ang_q), ang_avg);
    vel = {ang_avg[31:0], lin_avg[31:0]};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lin_gain   = longint'(RESET_LIN_GAIN);
      ang_gain   = longint'(RESET_ANG_GAIN);
      boost_gain = longint'(RESET_BOOST_GAIN);
      clear_window(LIN_CH, window_of(GAIN_W'(RESET_LEN)));
      clear_window(ANG_CH, window_of(GAIN_W'(RESET_LEN)));
      expected_velocities.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LINEAR_GAIN:  lin_gain   = longint'(cfg_wr_data);
          REG_ANGULAR_GAIN: ang_gain   = longint'(cfg_wr_data);
          REG_BOOST_GAIN:   boost_gain = longint'(cfg_wr_data);
          REG_LINEAR_LEN:   clear_window(LIN_CH, window_of(cfg_wr_data));
          REG_ANGULAR_LEN:  clear_window(ANG_CH, window_of(cfg_wr_data));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        mix_and_smooth(in_tdata, fresh);
        expected_velocities = {expected_velocities, fresh};
      end
      if (out_tvalid && out_tready) begin
        if (expected_velocities.size() == 0) begin
          mismatches++;
          $display("%0t: velocity beat %h arrived, expected none", $time, out_tdata);
        end else begin
          want = expected_velocities.pop_front();
          if (want[31:0] !== out_tdata[31:0]) begin
            mismatches++;
            $display("%0t: linear_velocity expected %0d actual %0d", $time,
                     $signed(want[31:0]), $signed(out_tdata[31:0]));
          end
          if (want[63:32] !== out_tdata[63:32]) begin
            mismatches++;
            $display("%0t: angular_velocity expected %0d actual %0d", $time,
                     $signed(want[63:32]), $signed(out_tdata[63:32]));
          end
        end
      end
    end
    pending_velocities = expected_velocities.size();
  end

endmodule

/* tb/sv/joystick_twist_mixer_smoother_unit_test.sv */
// Testbench top for the joystick twist mixer smoother: clock, reset, stimulus and verdict.
module joystick_twist_mixer_smoother_unit_test;
  import jtms_pkg::*;

  localparam int                   NUM_PHASES = 11;
  localparam int                   PHASE_BEATS = 150;
  localparam int                   STEADY_PHASE = 3;
  localparam int                   DRAIN_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd5;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [63:0]          out_tdata;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_wr_data;
  logic                 steady;
  int                   pending_velocities;
  int                   mismatch_count;
  logic [15:0]          lin_axis;
  logic [15:0]          ang_axis;

  always #10 clk = ~clk;

  joystick_twist_mixer_smoother_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  twist_mix_monitor monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wr_data        (cfg_wr_data),
    .pending_velocities (pending_velocities),
    .mismatches         (mismatch_count)
  );

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 33);
  end

  function automatic logic [31:0] corner_pair(input int i);
    case (i)
      0:       return {16'h0000, 16'h0000};
      1:       return {16'h7FFF, 16'h7FFF};
      2:       return {16'h8000, 16'h8000};
      3:       return {16'h7FFF, 16'h8000};
      4:       return {16'h8000, 16'h7FFF};
      5:       return {16'hFFFF, 16'h0001};
      6:       return {16'h0001, 16'hFFFF};
      default: return {16'h7FFF, 16'h0000};
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'(256);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_len();
    case ($urandom_range(0, 4))
      0:       return GAIN_W'($urandom);
      1:       return GAIN_W'(MAX_WINDOW);
      2:       return GAIN_W'(1);
      default: return GAIN_W'($urandom_range(1, MAX_WINDOW));
    endcase
  endfunction

  function automatic logic [15:0] pick_axis(input logic [15:0] prev);
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return prev;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [15:0] lin, input logic [15:0] ang);
    if (!steady && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ang, lin};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_corners();
    logic [31:0] pair;
    for (int i = 0; i < 8; i++) begin
      pair = corner_pair(i);
      send_beat(pair[15:0], pair[31:16]);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_velocities != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= REG_LINEAR_GAIN;
    cfg_wr_data <= '0;
    steady      <= 1'b0;
    lin_axis     = '0;
    ang_axis     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_corners();
    settle();
    write_reg(REG_LINEAR_GAIN, 16'hFFFF);
    write_reg(REG_ANGULAR_GAIN, 16'hFFFF);
    write_reg(REG_BOOST_GAIN, 16'hFFFF);
    write_reg(REG_LINEAR_LEN, 16'h0000);
    write_reg(REG_ANGULAR_LEN, 16'h001F);
    write_reg(REG_NONE, 16'hFFFF);
    finish_writes();
    send_corners();
    settle();
    write_reg(REG_LINEAR_GAIN, 16'h0080);
    write_reg(REG_ANGULAR_GAIN, 16'h0001);
    write_reg(REG_BOOST_GAIN, 16'h0100);
    write_reg(REG_LINEAR_LEN, 16'hFFF0);
    write_reg(REG_ANGULAR_LEN, 16'hFFE1);
    finish_writes();
    send_corners();
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_reg(REG_LINEAR_GAIN, pick_gain());
      write_reg(REG_ANGULAR_GAIN, pick_gain());
      write_reg(REG_BOOST_GAIN, pick_gain());
      if ($urandom_range(0, 2) != 0) begin
        write_reg(REG_LINEAR_LEN, pick_len());
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(REG_ANGULAR_LEN, pick_len());
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'(REG_NONE + $urandom_range(0, 2)), GAIN_W'($urandom));
      end
      finish_writes();
      steady <= (phase == STEADY_PHASE);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        lin_axis = pick_axis(lin_axis);
        ang_axis = pick_axis(ang_axis);
        send_beat(lin_axis, ang_axis);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("joystick_twist_mixer_smoother_unit_test: PASS");
    end else begin
      $display("joystick_twist_mixer_smoother_unit_test: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("joystick_twist_mixer_smoother_unit_test: FAIL");
    $finish;
  end

endmodule
